FILE: rtl/core/bdq_pkg.sv
// types and codes shared by the bounded deque with search
package bdq_pkg;

	typedef logic signed [31:0] word_t;

	typedef enum logic [3:0] {
		REQ_PUSH_BACK  = 4'd0,
		REQ_PUSH_FRONT = 4'd1,
		REQ_POP_FRONT  = 4'd2,
		REQ_POP_BACK   = 4'd3,
		REQ_REMOVE_AT  = 4'd4,
		REQ_REMOVE_VAL = 4'd5,
		REQ_FIND       = 4'd6,
		REQ_PEEK_FRONT = 4'd7,
		REQ_PEEK_BACK  = 4'd8,
		REQ_CLEAR      = 4'd9
	} req_code_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_FROM_LEFT,
		OP_FROM_RIGHT
	} cell_op_t;

	typedef struct packed {
		logic [3:0] req_type;
		word_t      value;
		logic [4:0] index;
	} req_t;

	typedef struct packed {
		word_t      data;
		logic [3:0] position;
		logic [2:0] status;
		logic [4:0] count;
	} rsp_t;

endpackage

FILE: rtl/core/bdq_stream_if.sv
// valid/ready stream interface carrying one payload word
interface bdq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/bounded_deque_with_search.sv
// top level of the bounded deque with search: cell chain, select tree and control
// Bounded ordered store of up to DEPTH signed 32-bit words, front at position 0.
// Channels: req (sink) carries req_type, value and index; rsp (source) carries
// data, position, status and count. Each request gives exactly one response.
// Both use valid/ready, a transfer happens when both are high at a clock edge.
// Push, clear, unused codes and requests that fail early (empty, full, index
// out of range) answer in the cycle after the transfer.
// Pops, peeks, remove at, remove value and find load a select into a binary
// tree (one-hot, but a value search may mark several cells) and reduce it one
// level per cycle, then apply the shift in the cell chain.
// One request is in flight at a time; req.ready is high when the control is
// idle and the response register is empty or being drained in the same cycle.
// If the receiver stalls, the response holds and no new request is taken.
// Reset empties the store at once; cell contents are not cleared and are
// never read before they are written.
module bounded_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bdq_stream_if.sink    req,
	bdq_stream_if.source  rsp
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int LV   = IW;
	localparam int TP   = 1 << LV;
	localparam int LCW  = $clog2(LV + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REDUCE,
		S_APPLY
	} state_t;

	state_t                  state_q;
	logic [LCW-1:0]          lvl_q;
	logic [3:0]              req_q;
	logic [CW-1:0]           count_q;
	logic                    rsp_valid_q;
	bdq_pkg::rsp_t           rsp_q;

	bdq_pkg::cell_op_t       cell_op [DEPTH];
	bdq_pkg::word_t          cell_word [DEPTH];
	logic [DEPTH-1:0]        cell_match;
	logic [DEPTH-1:0]        leaf_sel;

	logic                    nd_found_q [TP];
	logic [IW-1:0]           nd_pos_q [TP];
	bdq_pkg::word_t          nd_word_q [TP];

	logic                    acc;
	logic [3:0]              rt;
	logic [CMPW-1:0]         idx_w;
	logic [CMPW-1:0]         cnt_w;
	logic                    is_empty;
	logic                    is_full;
	logic                    direct;
	logic                    push_ok;
	bdq_pkg::status_t        dir_status;
	logic [CW-1:0]           dir_count;

	bdq_pkg::word_t          ap_data;
	logic [3:0]              ap_pos;
	bdq_pkg::status_t        ap_status;
	logic                    ap_remove;
	logic [CW-1:0]           ap_count;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign acc      = req.valid && req.ready;
	assign rt       = req.payload.req_type;
	assign idx_w    = CMPW'(req.payload.index);
	assign cnt_w    = CMPW'(count_q);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

	// cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		bdq_pkg::word_t lw;
		bdq_pkg::word_t rw;
		if (g == 0) begin : g_first
			assign lw = req.payload.value;
		end else begin : g_mid_l
			assign lw = cell_word[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign rw = cell_word[g];
		end else begin : g_mid_r
			assign rw = cell_word[g+1];
		end
		bdq_cell u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.left_word  (lw),
			.right_word (rw),
			.load_word  (req.payload.value),
			.cmp_word   (req.payload.value),
			.word       (cell_word[g]),
			.match      (cell_match[g])
		);
	end

	// early decode of the incoming request
	always_comb begin
		direct     = 1'b1;
		push_ok    = 1'b0;
		dir_status = bdq_pkg::ST_OK;
		dir_count  = count_q;
		case (rt)
			bdq_pkg::REQ_PUSH_BACK, bdq_pkg::REQ_PUSH_FRONT: begin
				if (is_full) begin
					dir_status = bdq_pkg::ST_FULL;
				end else begin
					push_ok   = 1'b1;
					dir_count = count_q + CW'(1);
				end
			end
			bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK, bdq_pkg::REQ_REMOVE_VAL,
			bdq_pkg::REQ_FIND, bdq_pkg::REQ_PEEK_FRONT, bdq_pkg::REQ_PEEK_BACK: begin
				if (is_empty) begin
					dir_status = bdq_pkg::ST_EMPTY;
				end else begin
					direct = 1'b0;
				end
			end
			bdq_pkg::REQ_REMOVE_AT: begin
				if (is_empty) begin
					dir_status = bdq_pkg::ST_EMPTY;
				end else if (idx_w >= cnt_w) begin
					dir_status = bdq_pkg::ST_RANGE;
				end else begin
					direct = 1'b0;
				end
			end
			bdq_pkg::REQ_CLEAR: dir_count = '0;
			default: ;
		endcase
	end

	// select per cell, loaded into the tree leaves; one-hot but for value searches
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			case (rt)
				bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_PEEK_FRONT:
					leaf_sel[i] = (i == 0);
				bdq_pkg::REQ_POP_BACK, bdq_pkg::REQ_PEEK_BACK:
					leaf_sel[i] = (CW'(i) == count_q - CW'(1));
				bdq_pkg::REQ_REMOVE_AT:
					leaf_sel[i] = (CMPW'(i) == idx_w);
				bdq_pkg::REQ_REMOVE_VAL, bdq_pkg::REQ_FIND:
					leaf_sel[i] = cell_match[i] && (CW'(i) < count_q);
				default:
					leaf_sel[i] = 1'b0;
			endcase
		end
	end

	// select tree, reduced in place one level per cycle, lower index wins
	always_ff @(posedge clk) begin
		if (acc && !direct) begin
			for (int i = 0; i < DEPTH; i++) begin
				nd_found_q[i] <= leaf_sel[i];
				nd_pos_q[i]   <= IW'(i);
				nd_word_q[i]  <= cell_word[i];
			end
			for (int i = DEPTH; i < TP; i++) begin
				nd_found_q[i] <= 1'b0;
				nd_pos_q[i]   <= '0;
				nd_word_q[i]  <= '0;
			end
		end else if (state_q == S_REDUCE) begin
			for (int i = 0; i < TP / 2; i++) begin
				if (nd_found_q[2*i]) begin
					nd_found_q[i] <= 1'b1;
					nd_pos_q[i]   <= nd_pos_q[2*i];
					nd_word_q[i]  <= nd_word_q[2*i];
				end else begin
					nd_found_q[i] <= nd_found_q[2*i+1];
					nd_pos_q[i]   <= nd_pos_q[2*i+1];
					nd_word_q[i]  <= nd_word_q[2*i+1];
				end
			end
		end
	end

	// result of a tree lookup
	always_comb begin
		ap_data   = '0;
		ap_pos    = '0;
		ap_status = bdq_pkg::ST_OK;
		ap_remove = 1'b0;
		case (req_q)
			bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK,
			bdq_pkg::REQ_REMOVE_AT, bdq_pkg::REQ_REMOVE_VAL: begin
				if (nd_found_q[0]) begin
					ap_data   = nd_word_q[0];
					ap_remove = 1'b1;
				end else begin
					ap_status = bdq_pkg::ST_NOTFOUND;
				end
			end
			bdq_pkg::REQ_FIND: begin
				if (nd_found_q[0]) begin
					ap_pos = 4'(nd_pos_q[0]);
				end else begin
					ap_status = bdq_pkg::ST_NOTFOUND;
				end
			end
			bdq_pkg::REQ_PEEK_FRONT, bdq_pkg::REQ_PEEK_BACK: ap_data = nd_word_q[0];
			default: ;
		endcase
		ap_count = ap_remove ? count_q - CW'(1) : count_q;
	end

	// per-cell operation: pushes at transfer, gap closing at apply
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = bdq_pkg::OP_HOLD;
			if (acc && push_ok) begin
				if (rt == bdq_pkg::REQ_PUSH_BACK) begin
					if (CW'(i) == count_q) begin
						cell_op[i] = bdq_pkg::OP_LOAD;
					end
				end else if (i == 0) begin
					cell_op[i] = bdq_pkg::OP_LOAD;
				end else begin
					cell_op[i] = bdq_pkg::OP_FROM_LEFT;
				end
			end else if (state_q == S_APPLY && ap_remove && IW'(i) >= nd_pos_q[0]) begin
				cell_op[i] = bdq_pkg::OP_FROM_RIGHT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			req_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						req_q <= rt;
						if (direct) begin
							count_q        <= dir_count;
							rsp_valid_q    <= 1'b1;
							rsp_q.data     <= '0;
							rsp_q.position <= '0;
							rsp_q.status   <= dir_status;
							rsp_q.count    <= 5'(dir_count);
						end else begin
							lvl_q   <= LCW'(LV);
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (lvl_q == LCW'(1)) begin
						state_q <= S_APPLY;
					end else begin
						lvl_q <= lvl_q - LCW'(1);
					end
				end
				S_APPLY: begin
					count_q        <= ap_count;
					rsp_valid_q    <= 1'b1;
					rsp_q.data     <= ap_data;
					rsp_q.position <= ap_pos;
					rsp_q.status   <= ap_status;
					rsp_q.count    <= 5'(ap_count);
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the store never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds depth");

	// no request is taken while a lookup is in progress
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REDUCE || state_q == S_APPLY) |-> !req.ready)
		else $error("ready while busy");

	// an early answer appears in the cycle after its transfer
	a_direct_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && direct) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("missing early response");

	// a full status is only reported with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == bdq_pkg::ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full status with free room");

endmodule

FILE: rtl/core/bdq_cell.sv
// one storage cell of the deque chain: holds a word, shifts with its neighbors
module bdq_cell (
	input  logic             clk,
	input  bdq_pkg::cell_op_t op,
	input  bdq_pkg::word_t   left_word,
	input  bdq_pkg::word_t   right_word,
	input  bdq_pkg::word_t   load_word,
	input  bdq_pkg::word_t   cmp_word,
	output bdq_pkg::word_t   word,
	output logic             match
);

	bdq_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		case (op)
			bdq_pkg::OP_LOAD:       word_q <= load_word;
			bdq_pkg::OP_FROM_LEFT:  word_q <= left_word;
			bdq_pkg::OP_FROM_RIGHT: word_q <= right_word;
			default:                word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == cmp_word);

endmodule
